/* design/btnf_pkg.sv */
// Shared constants, status codes and helpers for the boundary tag next-fit allocator.
// No dependencies; used by the allocator top level and its port checker.
`default_nettype none

package btnf_pkg;

  // Heap geometry
  localparam int HEAP_BYTES = 65536;
  localparam int HEAP_WORDS = HEAP_BYTES / 4;
  localparam int IDX_W      = $clog2(HEAP_WORDS);
  localparam int TAG_W      = $clog2(HEAP_BYTES) + 1;
  // Working address width: room for sums of a few block sizes and wrapped underflow
  localparam int ADDR_W     = $clog2(HEAP_BYTES) + 4;

  localparam int MIN_BLOCK     = 16;
  localparam int FIRST_PAYLOAD = 8;
  localparam logic [15:0] CHUNK_RESET = 16'd4096;

  // Request commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_NOMEM   = 2'd1;
  localparam logic [1:0] STAT_IGNORED = 2'd2;

  // Bytes added for a growth request of ext bytes: whole words, rounded to an even count
  function automatic logic [ADDR_W-1:0] grow_bytes(input logic [ADDR_W-1:0] ext);
    logic [ADDR_W-1:0] words;
    words = ext >> 2;
    if (words[0]) begin
      words = words + ADDR_W'(1);
    end
    return words << 2;
  endfunction

endpackage

`default_nettype wire

/* design/boundary_tag_next_fit_allocator.sv */
// Boundary tag heap allocator with next-fit search, one tag memory and a sequencer.
// Depends on btnf_pkg for geometry, status codes and the growth helper.
`default_nettype none

// Usage:
//  Request channel (in_valid/in_stall): command, request_size, block_address.
//  A request is taken when in_valid is high and in_stall low. in_stall is high
//  while a request is being worked on; one request is in the block at a time.
//  Result channel (out_valid/out_stall): result_address and status, held in an
//  output register, so the next request may be taken while a result waits.
//  Each tag access uses the single memory port, with the read data
//  registered and available the cycle after the address. An allocate
//  takes longer for each block the next-fit search visits, as the search
//  walks the tag memory. The first request that is not a free of address
//  zero also lays out the heap.
//  Reset (rst, synchronous) clears the break, the rover and the ready flag and
//  sets the chunk register to 4096. Tag memory contents are not cleared; the
//  heap is laid out on the first request other than a free of address zero.
//  When the receiver stalls, the result holds in the output register; a further
//  finished result waits inside the block until the register frees up.
//  cfg_write_enable/cfg_write_data write the growth chunk register.
module boundary_tag_next_fit_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_enable,
  input  wire logic [15:0] cfg_write_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        command,
  input  wire logic [15:0] request_size,
  input  wire logic [15:0] block_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      result_address,
  output logic [1:0]       status
);

  localparam int AW = btnf_pkg::ADDR_W;
  localparam int TW = btnf_pkg::TAG_W;
  localparam int NS = 59;

  typedef enum logic [NS-1:0] {
    S_IDLE  = NS'(1) << 0,  S_FR_RD = NS'(1) << 1,  S_FR_S  = NS'(1) << 2,
    S_FR_W1 = NS'(1) << 3,  S_FR_R2 = NS'(1) << 4,  S_FR_W2 = NS'(1) << 5,
    S_LY_W0 = NS'(1) << 6,  S_LY_W1 = NS'(1) << 7,  S_LY_W2 = NS'(1) << 8,
    S_LY_W3 = NS'(1) << 9,  S_LY_END = NS'(1) << 10, S_AL_0 = NS'(1) << 11,
    S_S1_RD = NS'(1) << 12, S_S1_CHK = NS'(1) << 13, S_S2_TOP = NS'(1) << 14,
    S_S2_CHK = NS'(1) << 15, S_GR_0 = NS'(1) << 16, S_GR_R1 = NS'(1) << 17,
    S_GR_W2 = NS'(1) << 18, S_GR_R3 = NS'(1) << 19, S_GR_W4 = NS'(1) << 20,
    S_M_0   = NS'(1) << 21, S_M_1   = NS'(1) << 22, S_M_2   = NS'(1) << 23,
    S_M_3   = NS'(1) << 24, S_M_4   = NS'(1) << 25, S_M_5   = NS'(1) << 26,
    S_MA_W1 = NS'(1) << 27, S_MA_R  = NS'(1) << 28, S_MA_W2 = NS'(1) << 29,
    S_MB_R0 = NS'(1) << 30, S_MB_R1 = NS'(1) << 31, S_MB_S  = NS'(1) << 32,
    S_MB_W1 = NS'(1) << 33, S_MB_R2 = NS'(1) << 34, S_MB_W2 = NS'(1) << 35,
    S_MC_R0 = NS'(1) << 36, S_MC_R1 = NS'(1) << 37, S_MC_S1 = NS'(1) << 38,
    S_MC_R2 = NS'(1) << 39, S_MC_R3 = NS'(1) << 40, S_MC_S2 = NS'(1) << 41,
    S_MC_W1 = NS'(1) << 42, S_MC_R4 = NS'(1) << 43, S_MC_R5 = NS'(1) << 44,
    S_MC_W2 = NS'(1) << 45, S_MP_R  = NS'(1) << 46, S_MP_S  = NS'(1) << 47,
    S_RV_R  = NS'(1) << 48, S_RV_C  = NS'(1) << 49, S_MR    = NS'(1) << 50,
    S_PT_R  = NS'(1) << 51, S_PT_C  = NS'(1) << 52, S_PT_W  = NS'(1) << 53,
    S_PT_RD = NS'(1) << 54, S_PT_F  = NS'(1) << 55, S_PT_N  = NS'(1) << 56,
    S_PT_N2 = NS'(1) << 57, S_DONE  = NS'(1) << 58
  } state_t;

  state_t state, state_next;

  // Control registers
  logic [15:0]   chunk;
  logic [AW-1:0] brk;
  logic [AW-1:0] rover;
  logic          ready;

  // Working registers of the current request
  logic          cmd;
  logic [15:0]   req;
  logic [15:0]   addr;
  logic [AW-1:0] bp, prvbp, t, s, start, res, c;
  logic [TW-1:0] fsz, pv, asize;
  logic [AW-1:0] gsize;
  logic          pa, split, glay, mfree;
  logic [1:0]    stat;

  // Tag memory and its port
  logic [TW-1:0] tag_mem [btnf_pkg::HEAP_WORDS];
  logic [TW-1:0] mem_q;
  logic          mem_oob;
  logic [AW-1:0] mem_a;
  logic          mem_we;
  logic [TW-1:0] mem_wd;
  logic          a_in;
  logic [btnf_pkg::IDX_W-1:0] a_idx;

  // Read value, size and allocated bit
  logic [TW-1:0] rv;
  logic [AW-1:0] rsz;
  logic          ral;

  logic [15:0]   chunk_eff;
  logic [TW-1:0] asize_calc;
  logic [AW-1:0] ext_alloc;
  logic          fit;
  logic          grow_ok;
  logic          accept;

  assign a_in  = mem_a < AW'(btnf_pkg::HEAP_BYTES);
  assign a_idx = mem_a[btnf_pkg::IDX_W+1:2];
  assign rv    = mem_oob ? '0 : mem_q;
  assign rsz   = AW'({rv[TW-1:3], 3'b000});
  assign ral   = rv[0];

  assign chunk_eff  = (chunk < 16'(btnf_pkg::MIN_BLOCK)) ? 16'(btnf_pkg::MIN_BLOCK) : chunk;
  assign asize_calc = (req <= 16'd8) ? TW'(btnf_pkg::MIN_BLOCK)
                                     : ((TW'(req) + TW'(15)) & ~TW'(7));
  assign ext_alloc  = (asize > TW'(chunk_eff)) ? AW'(asize) : AW'(chunk_eff);
  assign fit        = !ral && (AW'(asize) <= rsz);
  assign grow_ok    = (brk + gsize) <= AW'(btnf_pkg::HEAP_BYTES);
  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state != S_IDLE);

  // Hold the tag memory: one access a cycle, registered read
  always_ff @(posedge clk) begin
    if (mem_we && a_in) begin
      tag_mem[a_idx] <= mem_wd;
    end
    mem_q   <= tag_mem[a_idx];
    mem_oob <= !a_in;
  end

  // Sequence the steps and drive the memory port
  always_comb begin
    state_next = state;
    mem_a      = '0;
    mem_we     = 1'b0;
    mem_wd     = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (command == btnf_pkg::CMD_FREE) begin
            state_next = (block_address == 16'd0) ? S_DONE : S_FR_RD;
          end else begin
            state_next = ready ? S_AL_0 : S_LY_W0;
          end
        end
      end
      S_FR_RD: begin
        mem_a = AW'(addr) - AW'(4);
        state_next = S_FR_S;
      end
      S_FR_S: begin
        state_next = ready ? S_FR_W1 : S_LY_W0;
      end
      S_FR_W1: begin
        mem_a = AW'(addr) - AW'(4); mem_we = 1'b1; mem_wd = fsz;
        state_next = S_FR_R2;
      end
      S_FR_R2: begin
        mem_a = AW'(addr) - AW'(4);
        state_next = S_FR_W2;
      end
      S_FR_W2: begin
        mem_a = AW'(addr) + rsz - AW'(8); mem_we = 1'b1; mem_wd = fsz;
        state_next = S_M_0;
      end
      S_LY_W0: begin
        mem_a = AW'(0); mem_we = 1'b1; mem_wd = TW'(0);
        state_next = S_LY_W1;
      end
      S_LY_W1: begin
        mem_a = AW'(4); mem_we = 1'b1; mem_wd = TW'(9);
        state_next = S_LY_W2;
      end
      S_LY_W2: begin
        mem_a = AW'(8); mem_we = 1'b1; mem_wd = TW'(9);
        state_next = S_LY_W3;
      end
      S_LY_W3: begin
        mem_a = AW'(12); mem_we = 1'b1; mem_wd = TW'(1);
        state_next = S_GR_0;
      end
      S_LY_END: begin
        state_next = (cmd == btnf_pkg::CMD_FREE) ? S_FR_W1 : S_AL_0;
      end
      S_AL_0: begin
        state_next = (req == 16'd0) ? S_DONE : S_S1_RD;
      end
      S_S1_RD: begin
        mem_a = rover - AW'(4);
        state_next = S_S1_CHK;
      end
      S_S1_CHK: begin
        if (rsz == '0) begin
          state_next = S_S2_TOP;
        end else if (fit) begin
          state_next = S_PT_R;
        end else begin
          state_next = S_S1_RD;
        end
      end
      S_S2_TOP: begin
        mem_a = rover - AW'(4);
        state_next = (rover < start) ? S_S2_CHK : S_GR_0;
      end
      S_S2_CHK: begin
        if (rsz == '0) begin
          state_next = S_GR_0;
        end else if (fit) begin
          state_next = S_PT_R;
        end else begin
          state_next = S_S2_TOP;
        end
      end
      S_GR_0: begin
        if (grow_ok) begin
          mem_a = brk - AW'(4); mem_we = 1'b1; mem_wd = TW'(gsize);
          state_next = S_GR_R1;
        end else begin
          state_next = glay ? S_LY_END : S_DONE;
        end
      end
      S_GR_R1: begin
        mem_a = bp - AW'(4);
        state_next = S_GR_W2;
      end
      S_GR_W2: begin
        mem_a = bp + rsz - AW'(8); mem_we = 1'b1; mem_wd = TW'(gsize);
        state_next = S_GR_R3;
      end
      S_GR_R3: begin
        mem_a = bp - AW'(4);
        state_next = S_GR_W4;
      end
      S_GR_W4: begin
        mem_a = bp + rsz - AW'(4); mem_we = 1'b1; mem_wd = TW'(1);
        state_next = S_M_0;
      end
      // Merge: gather both neighbors' allocated bits
      S_M_0: begin
        mem_a = bp - AW'(8);
        state_next = S_M_1;
      end
      S_M_1: begin
        mem_a = bp - rsz - AW'(4);
        state_next = S_M_2;
      end
      S_M_2: begin
        mem_a = prvbp + rsz - AW'(8);
        state_next = S_M_3;
      end
      S_M_3: begin
        mem_a = bp - AW'(4);
        state_next = S_M_4;
      end
      S_M_4: begin
        mem_a = bp + rsz - AW'(4);
        state_next = S_M_5;
      end
      S_M_5: begin
        if (pa && ral) begin
          state_next = S_MR;
        end else if (pa) begin
          state_next = S_MA_W1;
        end else if (ral) begin
          state_next = S_MB_R0;
        end else begin
          state_next = S_MC_R0;
        end
      end
      // Merge with the next block only
      S_MA_W1: begin
        mem_a = bp - AW'(4); mem_we = 1'b1; mem_wd = TW'(s);
        state_next = S_MA_R;
      end
      S_MA_R: begin
        mem_a = bp - AW'(4);
        state_next = S_MA_W2;
      end
      S_MA_W2: begin
        mem_a = bp + rsz - AW'(8); mem_we = 1'b1; mem_wd = TW'(s);
        state_next = S_RV_R;
      end
      // Merge with the previous block only
      S_MB_R0: begin
        mem_a = bp - AW'(8);
        state_next = S_MB_R1;
      end
      S_MB_R1: begin
        mem_a = bp - rsz - AW'(4);
        state_next = S_MB_S;
      end
      S_MB_S: begin
        mem_a = bp - AW'(4);
        state_next = S_MB_W1;
      end
      S_MB_W1: begin
        mem_a = bp + rsz - AW'(8); mem_we = 1'b1; mem_wd = TW'(s);
        state_next = S_MB_R2;
      end
      S_MB_R2: begin
        mem_a = bp - AW'(8);
        state_next = S_MB_W2;
      end
      S_MB_W2: begin
        mem_a = bp - rsz - AW'(4); mem_we = 1'b1; mem_wd = TW'(s);
        state_next = S_MP_R;
      end
      // Merge with both neighbors
      S_MC_R0: begin
        mem_a = bp - AW'(8);
        state_next = S_MC_R1;
      end
      S_MC_R1: begin
        mem_a = bp - rsz - AW'(4);
        state_next = S_MC_S1;
      end
      S_MC_S1: begin
        mem_a = bp - AW'(4);
        state_next = S_MC_R2;
      end
      S_MC_R2: begin
        mem_a = bp + rsz - AW'(4);
        state_next = S_MC_R3;
      end
      S_MC_R3: begin
        mem_a = t + rsz - AW'(8);
        state_next = S_MC_S2;
      end
      S_MC_S2: begin
        mem_a = bp - AW'(8);
        state_next = S_MC_W1;
      end
      S_MC_W1: begin
        mem_a = bp - rsz - AW'(4); mem_we = 1'b1; mem_wd = TW'(s);
        state_next = S_MC_R4;
      end
      S_MC_R4: begin
        mem_a = bp - AW'(4);
        state_next = S_MC_R5;
      end
      S_MC_R5: begin
        mem_a = bp + rsz - AW'(4);
        state_next = S_MC_W2;
      end
      S_MC_W2: begin
        mem_a = t + rsz - AW'(8); mem_we = 1'b1; mem_wd = TW'(s);
        state_next = S_MP_R;
      end
      // Step back to the previous block, then fix up the rover
      S_MP_R: begin
        mem_a = bp - AW'(8);
        state_next = S_MP_S;
      end
      S_MP_S: begin
        state_next = S_RV_R;
      end
      S_RV_R: begin
        mem_a = bp - AW'(4);
        state_next = S_RV_C;
      end
      S_RV_C: begin
        state_next = S_MR;
      end
      S_MR: begin
        if (mfree) begin
          state_next = S_DONE;
        end else if (glay) begin
          state_next = S_LY_END;
        end else begin
          state_next = S_PT_R;
        end
      end
      // Place the block, splitting off a free remainder when it is at least MIN_BLOCK bytes
      S_PT_R: begin
        mem_a = bp - AW'(4);
        state_next = S_PT_C;
      end
      S_PT_C: begin
        state_next = S_PT_W;
      end
      S_PT_W: begin
        mem_a = bp - AW'(4); mem_we = 1'b1; mem_wd = pv;
        state_next = S_PT_RD;
      end
      S_PT_RD: begin
        mem_a = bp - AW'(4);
        state_next = S_PT_F;
      end
      S_PT_F: begin
        mem_a = bp + rsz - AW'(8); mem_we = 1'b1; mem_wd = pv;
        state_next = split ? S_PT_N : S_DONE;
      end
      S_PT_N: begin
        mem_a = bp - AW'(4);
        state_next = S_PT_N2;
      end
      S_PT_N2: begin
        state_next = S_PT_W;
      end
      S_DONE: begin
        if (!(out_valid && out_stall)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance the control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      chunk <= btnf_pkg::CHUNK_RESET;
      brk   <= '0;
      rover <= '0;
      ready <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_enable) begin
        chunk <= cfg_write_data;
      end
      // Drop the result once taken, load a new one from the done state
      if (state == S_DONE && !(out_valid && out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LY_W3:  begin brk <= AW'(16); ready <= 1'b1; end
        S_LY_END: rover <= AW'(btnf_pkg::FIRST_PAYLOAD);
        S_S1_CHK: begin
          if (rsz == '0) begin
            rover <= AW'(btnf_pkg::FIRST_PAYLOAD);
          end else if (!fit) begin
            rover <= rover + rsz;
          end
        end
        S_S2_CHK: begin
          if (rsz != '0 && !fit) begin
            rover <= rover + rsz;
          end
        end
        S_GR_0: begin
          if (grow_ok) begin
            brk <= brk + gsize;
          end
        end
        S_RV_C: begin
          if (rover > bp && rover < bp + rsz) begin
            rover <= bp;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the working registers of the request
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd  <= command;
          req  <= request_size;
          addr <= block_address;
          res  <= '0;
          stat <= (command == btnf_pkg::CMD_FREE && block_address == 16'd0)
                  ? btnf_pkg::STAT_IGNORED : btnf_pkg::STAT_DONE;
        end
      end
      S_FR_S:  fsz <= rv & ~TW'(7);
      S_FR_W2: begin bp <= AW'(addr); mfree <= 1'b1; end
      S_LY_W3: begin gsize <= btnf_pkg::grow_bytes(AW'(chunk_eff)); glay <= 1'b1; end
      S_AL_0: begin
        asize <= asize_calc;
        start <= rover;
        if (req == 16'd0) begin
          stat <= btnf_pkg::STAT_IGNORED;
        end
      end
      S_S1_CHK: begin
        if (rsz != '0 && fit) begin
          bp <= rover;
        end
      end
      S_S2_TOP: begin
        if (!(rover < start)) begin
          gsize <= btnf_pkg::grow_bytes(ext_alloc);
          glay  <= 1'b0;
        end
      end
      S_S2_CHK: begin
        if (rsz == '0) begin
          gsize <= btnf_pkg::grow_bytes(ext_alloc);
          glay  <= 1'b0;
        end else if (fit) begin
          bp <= rover;
        end
      end
      S_GR_0: begin
        if (grow_ok) begin
          bp <= brk;
        end else if (!glay) begin
          stat <= btnf_pkg::STAT_NOMEM;
          res  <= '0;
        end
      end
      S_GR_W4: mfree <= 1'b0;
      S_M_1:   prvbp <= bp - rsz;
      S_M_3:   pa <= ral;
      S_M_4:   s <= rsz;
      S_M_5: begin
        if (pa && !ral) begin
          s <= s + rsz;
        end
      end
      S_MB_S:  s <= s + rsz;
      S_MC_S1: s <= s + rsz;
      S_MC_R2: t <= bp + rsz;
      S_MC_S2: s <= s + rsz;
      S_MC_R5: t <= bp + rsz;
      S_MP_S:  bp <= bp - rsz;
      S_PT_C: begin
        c   <= rsz;
        res <= bp;
        if (rsz >= AW'(asize) + AW'(btnf_pkg::MIN_BLOCK)) begin
          pv    <= asize | TW'(1);
          split <= 1'b1;
        end else begin
          pv    <= rv | TW'(1);
          split <= 1'b0;
        end
      end
      S_PT_N2: begin
        bp    <= bp + rsz;
        pv    <= TW'(c - AW'(asize));
        split <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (state == S_DONE && !(out_valid && out_stall)) begin
      result_address <= res[15:0];
      status         <= stat;
    end
  end

endmodule

`default_nettype wire

/* design/btnf_checker.sv */
// Port-level checker for the boundary tag next-fit allocator, bound to the top level.
// Depends on btnf_pkg for status codes.
`default_nettype none

module btnf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] result_address,
  input wire logic [1:0]  status
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_address) && $stable(status))
    else $error("stalled result changed");

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == btnf_pkg::STAT_DONE || status == btnf_pkg::STAT_NOMEM ||
                   status == btnf_pkg::STAT_IGNORED))
    else $error("undefined status code");

  // Failed or ignored requests return no address
  a_no_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != btnf_pkg::STAT_DONE |-> result_address == 16'd0)
    else $error("address returned with error status");

  // A taken request keeps the block busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

endmodule

bind boundary_tag_next_fit_allocator btnf_checker u_btnf_checker (.*);

`default_nettype wire

/* bench/boundary_tag_next_fit_allocator_test.sv */
// Self-checking bench for the boundary tag next-fit heap allocator.
// Depends on btnf_pkg and boundary_tag_next_fit_allocator; predicts every reply in place.
`timescale 1ns / 100ps

module boundary_tag_next_fit_allocator_test;
  import btnf_pkg::*;

  localparam longint CYCLE_LIMIT = 10_000_000;

  typedef struct {
    logic [15:0] addr;
    logic [1:0]  stat;
  } reply_t;

  typedef struct {
    logic        cmd;
    logic [15:0] size;
    logic [15:0] addr;
    bit          typed;
    logic [15:0] exp_addr;
    logic [1:0]  exp_stat;
  } dir_row_t;

  logic clk, rst;
  logic cfg_write_enable;
  logic [15:0] cfg_write_data;
  logic in_valid, in_stall;
  logic command;
  logic [15:0] request_size, block_address;
  logic out_valid, out_stall;
  logic [15:0] result_address;
  logic [1:0] status;

  reply_t expected_replies[$];
  logic [15:0] live_blocks[$];
  int errors = 0;
  longint cycles = 0;
  bit quiet = 0;

  // Shadow heap state
  int unsigned shadow_tags [HEAP_WORDS];
  longint unsigned shadow_break = 0;
  longint unsigned shadow_rover = 0;
  bit shadow_ready = 0;
  longint unsigned shadow_chunk = CHUNK_RESET;

  boundary_tag_next_fit_allocator u_top (
    .clk(clk), .rst(rst),
    .cfg_write_enable(cfg_write_enable), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .request_size(request_size), .block_address(block_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_address(result_address), .status(status)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Tag access helpers
  function automatic longint unsigned tag_rd(longint unsigned a);
    return (a < HEAP_BYTES) ? shadow_tags[a >> 2] : 0;
  endfunction

  function automatic void tag_wr(longint unsigned a, longint unsigned v);
    if (a < HEAP_BYTES) shadow_tags[a >> 2] = int'(v);
  endfunction

  function automatic longint unsigned tag_size(longint unsigned a);
    return tag_rd(a) & ~64'd7;
  endfunction

  function automatic bit tag_alloc(longint unsigned a);
    return tag_rd(a) & 1;
  endfunction

  function automatic longint unsigned foot_of(longint unsigned bp);
    return bp + tag_size(bp - 4) - 8;
  endfunction

  function automatic longint unsigned next_of(longint unsigned bp);
    return bp + tag_size(bp - 4);
  endfunction

  function automatic longint unsigned prev_of(longint unsigned bp);
    return bp - tag_size(bp - 8);
  endfunction

  // Merge a free block with free neighbors, pull the rover back if inside
  function automatic longint unsigned coalesce(longint unsigned bp);
    bit pa, na;
    longint unsigned s;
    pa = tag_alloc(foot_of(prev_of(bp)));
    na = tag_alloc(next_of(bp) - 4);
    s = tag_size(bp - 4);
    if (pa && na) return bp;
    if (pa) begin
      s += tag_size(next_of(bp) - 4);
      tag_wr(bp - 4, s);
      tag_wr(foot_of(bp), s);
    end else if (na) begin
      s += tag_size(prev_of(bp) - 4);
      tag_wr(foot_of(bp), s);
      tag_wr(prev_of(bp) - 4, s);
      bp = prev_of(bp);
    end else begin
      s += tag_size(prev_of(bp) - 4) + tag_size(foot_of(next_of(bp)));
      tag_wr(prev_of(bp) - 4, s);
      tag_wr(foot_of(next_of(bp)), s);
      bp = prev_of(bp);
    end
    if (shadow_rover > bp && shadow_rover < next_of(bp)) shadow_rover = bp;
    return bp;
  endfunction

  function automatic bit extend_heap(longint unsigned words, output longint unsigned bp);
    longint unsigned size;
    size = (words[0] ? words + 1 : words) * 4;
    bp = 0;
    if (shadow_break + size > HEAP_BYTES) return 0;
    bp = shadow_break;
    shadow_break += size;
    tag_wr(bp - 4, size);
    tag_wr(foot_of(bp), size);
    tag_wr(next_of(bp) - 4, 1);
    bp = coalesce(bp);
    return 1;
  endfunction

  function automatic longint unsigned eff_chunk();
    return (shadow_chunk < MIN_BLOCK) ? MIN_BLOCK : shadow_chunk;
  endfunction

  function automatic void lay_out_heap();
    longint unsigned bp;
    shadow_break = 16;
    tag_wr(0, 0);
    tag_wr(4, 9);
    tag_wr(8, 9);
    tag_wr(12, 1);
    shadow_ready = 1;
    void'(extend_heap(eff_chunk() / 4, bp));
    shadow_rover = FIRST_PAYLOAD;
  endfunction

  function automatic bit block_fits(longint unsigned bp, longint unsigned asize);
    return !tag_alloc(bp - 4) && asize <= tag_size(bp - 4);
  endfunction

  // Next-fit walk from the rover, wrapping once to the first block
  function automatic bit next_fit(longint unsigned asize, output longint unsigned bp);
    longint unsigned start;
    start = shadow_rover;
    bp = 0;
    for (; tag_size(shadow_rover - 4) > 0; shadow_rover = next_of(shadow_rover))
      if (block_fits(shadow_rover, asize)) begin
        bp = shadow_rover;
        return 1;
      end
    for (shadow_rover = FIRST_PAYLOAD; shadow_rover < start;
         shadow_rover = next_of(shadow_rover)) begin
      if (tag_size(shadow_rover - 4) == 0) break;
      if (block_fits(shadow_rover, asize)) begin
        bp = shadow_rover;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic void place_block(longint unsigned bp, longint unsigned asize);
    longint unsigned c;
    c = tag_size(bp - 4);
    if (c >= asize + MIN_BLOCK) begin
      tag_wr(bp - 4, asize | 1);
      tag_wr(foot_of(bp), asize | 1);
      bp = next_of(bp);
      tag_wr(bp - 4, c - asize);
      tag_wr(foot_of(bp), c - asize);
    end else begin
      tag_wr(bp - 4, c | 1);
      tag_wr(foot_of(bp), c | 1);
    end
  endfunction

  // Compute the reply of one request and advance the shadow heap
  function automatic reply_t predict_heap_reply(logic cmd, logic [15:0] req,
                                                logic [15:0] addr);
    reply_t r;
    longint unsigned asize, ext, bp, s;
    r.addr = '0;
    r.stat = STAT_DONE;
    if (cmd == CMD_ALLOC) begin
      if (!shadow_ready) lay_out_heap();
      if (req == 0) begin
        r.stat = STAT_IGNORED;
        return r;
      end
      asize = (req <= 8) ? MIN_BLOCK : 8 * ((longint'(req) + 15) / 8);
      if (!next_fit(asize, bp)) begin
        ext = (asize > eff_chunk()) ? asize : eff_chunk();
        if (!extend_heap(ext / 4, bp)) begin
          r.stat = STAT_NOMEM;
          return r;
        end
      end
      place_block(bp, asize);
      r.addr = bp[15:0];
    end else begin
      if (addr == 0) begin
        r.stat = STAT_IGNORED;
        return r;
      end
      s = tag_size(longint'(addr) - 4);
      if (!shadow_ready) lay_out_heap();
      tag_wr(longint'(addr) - 4, s);
      tag_wr(foot_of(addr), s);
      void'(coalesce(addr));
    end
    return r;
  endfunction

  // Present one request, wait for acceptance, record the expected reply
  task automatic send_request(logic cmd, logic [15:0] size, logic [15:0] addr,
                              bit typed, reply_t typed_reply);
    int gap;
    reply_t r;
    gap = quiet ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    command <= cmd;
    request_size <= size;
    block_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_heap_reply(cmd, size, addr);
    if (typed && (r.addr !== typed_reply.addr || r.stat !== typed_reply.stat))
      $error("directed row: typed reply %0h/%0d disagrees with predictor %0h/%0d",
             typed_reply.addr, typed_reply.stat, r.addr, r.stat);
    expected_replies.push_back(typed ? typed_reply : r);
    // Track live payloads
    if (cmd == CMD_ALLOC && r.stat == STAT_DONE && r.addr != 0) live_blocks.push_back(r.addr);
    if (cmd == CMD_FREE)
      foreach (live_blocks[i])
        if (live_blocks[i] == addr || live_blocks[i] == (addr & ~16'd3)) begin
          live_blocks.delete(i);
          break;
        end
  endtask

  // Drain outstanding replies before touching the chunk register
  task automatic write_chunk(logic [15:0] value);
    @(negedge clk);
    in_valid <= 0;
    while (expected_replies.size() != 0) @(negedge clk);
    repeat (64) @(negedge clk);
    cfg_write_enable <= 1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_enable <= 0;
    shadow_chunk = value;
  endtask

  task automatic random_request();
    int r, k;
    logic [15:0] a, sz;
    reply_t none;
    none = '{addr: '0, stat: STAT_DONE};
    r = $urandom_range(0, 99);
    if (r < 3) begin
      send_request(CMD_FREE, 16'($urandom), 16'd0, 0, none);
    end else if (r < 6) begin
      send_request(CMD_ALLOC, 16'd0, 16'($urandom), 0, none);
    end else if (r < 50 && live_blocks.size() > 0) begin
      k = $urandom_range(0, live_blocks.size() - 1);
      a = live_blocks[k];
      // Rarely free with an offset inside the header word
      if (a[2:0] == 0 && $urandom_range(0, 99) == 0) a = a + 16'($urandom_range(1, 3));
      send_request(CMD_FREE, 16'($urandom), a, 0, none);
    end else begin
      k = $urandom_range(0, 99);
      if (k < 70) sz = 16'($urandom_range(1, 64));
      else if (k < 90) sz = 16'($urandom_range(65, 1024));
      else if (k < 97) sz = 16'($urandom_range(1025, 8192));
      else sz = 16'($urandom);
      send_request(CMD_ALLOC, sz, 16'($urandom), 0, none);
    end
  endtask

  dir_row_t directed [] = '{
    '{CMD_ALLOC, 16'd0,     16'd0,  1, 16'd0,  STAT_IGNORED},
    '{CMD_ALLOC, 16'd1,     16'd0,  1, 16'd16, STAT_DONE},
    '{CMD_ALLOC, 16'd8,     16'd0,  0, 16'd0,  STAT_DONE},
    '{CMD_ALLOC, 16'd9,     16'd0,  0, 16'd0,  STAT_DONE},
    '{CMD_ALLOC, 16'hFFFF,  16'd0,  1, 16'd0,  STAT_NOMEM},
    '{CMD_FREE,  16'hFFFF,  16'd0,  1, 16'd0,  STAT_IGNORED},
    '{CMD_ALLOC, 16'd16,    16'd0,  0, 16'd0,  STAT_DONE},
    '{CMD_ALLOC, 16'd4000,  16'd0,  0, 16'd0,  STAT_DONE},
    '{CMD_FREE,  16'd0,     16'd32, 1, 16'd0,  STAT_DONE},
    '{CMD_FREE,  16'd0,     16'd16, 1, 16'd0,  STAT_DONE},
    '{CMD_FREE,  16'd0,     16'd48, 1, 16'd0,  STAT_DONE},
    '{CMD_ALLOC, 16'd40000, 16'd0,  0, 16'd0,  STAT_DONE},
    '{CMD_ALLOC, 16'd24,    16'd0,  0, 16'd0,  STAT_DONE},
    '{CMD_ALLOC, 16'd32760, 16'd0,  0, 16'd0,  STAT_DONE},
    '{CMD_ALLOC, 16'd7,     16'd0,  0, 16'd0,  STAT_DONE}
  };

  logic [15:0] chunk_plan [] = '{16'd16, 16'd32768, 16'd0, 16'd20, 16'd1000, 16'd4096};

  // Stimulus
  initial begin
    reply_t tr;
    rst = 1;
    cfg_write_enable = 0;
    cfg_write_data = '0;
    in_valid = 0;
    command = CMD_ALLOC;
    request_size = '0;
    block_address = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    foreach (directed[i]) begin
      tr = '{addr: directed[i].exp_addr, stat: directed[i].exp_stat};
      send_request(directed[i].cmd, directed[i].size, directed[i].addr,
                   directed[i].typed, tr);
    end
    for (int n = 0; n < 90; n++) begin
      if (n % 40 == 0) quiet = !quiet;
      random_request();
    end
    foreach (chunk_plan[p]) begin
      write_chunk(chunk_plan[p]);
      for (int n = 0; n < 78; n++) begin
        if (n % 35 == 0) quiet = ($urandom_range(0, 2) == 0);
        random_request();
      end
    end
    @(negedge clk);
    in_valid <= 0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver stall pattern
  initial begin
    int n;
    out_stall = 0;
    @(negedge clk);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 14);
      repeat (n) begin
        out_stall <= 1;
        @(negedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Compare each accepted reply with the oldest expectation
  always @(posedge clk) begin
    reply_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        $error("reply with nothing expected: result_address %0h status %0d",
               result_address, status);
        errors++;
      end else begin
        e = expected_replies.pop_front();
        if (result_address !== e.addr) begin
          $error("result_address expected %0h actual %0h", e.addr, result_address);
          errors++;
        end
        if (status !== e.stat) begin
          $error("status expected %0d actual %0d", e.stat, status);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
